FILE: hw/rtl/pfla_pkg.sv
package pfla_pkg;

	// Field widths
	localparam int PAGE_W = 10;
	localparam int CNT_W  = 11;

	// Number of pages the store can hold, header page included
	localparam int                MAX_PAGES = 1 << PAGE_W;
	localparam logic [CNT_W-1:0]  MAX_COUNT = CNT_W'(MAX_PAGES);

	// Operation codes
	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE  = 2'd1;
	localparam logic [1:0] MODE_SET   = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_BAD_PAGE = 2'd2;

	// Request item
	typedef struct packed {
		logic [1:0]        mode;
		logic [PAGE_W-1:0] page_id;
		logic              mark_free;
		logic [PAGE_W-1:0] link_value;
	} pfla_req_t;

	// Response item
	typedef struct packed {
		logic [PAGE_W-1:0] result_page;
		logic              from_list;
		logic              list_dropped;
		logic [1:0]        status;
	} pfla_rsp_t;

endpackage

FILE: hw/rtl/pfla_ram.sv
module pfla_ram import pfla_pkg::*; #(
	parameter int WIDTH = PAGE_W,
	parameter int DEPTH = MAX_PAGES
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/page_free_list_allocator.sv
// Page allocator over a linked free list; page 0 is the header page.
//
// Request channel: an item (req) is taken at a rising edge with start high
// and busy low. Modes: allocate (pop list head, or append a fresh page past
// the page count), free (push page onto the list), set (overwrite a page's
// free mark and link).
// Response channel: every item gives one result on rsp, marked by done for
// exactly one cycle; done and rsp are registered in the execute state. The
// receiver cannot stall; each result must be sampled while done is high.
// An item is taken in the idle state, which reads the head's mark and link
// from the synchronous page memories; the execute state updates head, count
// and memories, and holds busy high, so no new item is taken until it ends.
// Configuration: cfg_we/cfg_wdata load the page count register (clamped to
// 1..1024); write only while no item is outstanding.
// Reset: list head clears to empty, page count to 1, and a clearing pass
// over all 1024 pages zeroes the free marks with busy held high. The link
// memory is not cleared.
module page_free_list_allocator import pfla_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pfla_req_t        req,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	output logic             done,
	output pfla_rsp_t        rsp
);

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;

	state_t            state_q;
	logic [PAGE_W-1:0] clr_addr_q;
	pfla_req_t         req_q;
	logic [PAGE_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	pfla_rsp_t         rsp_q;

	logic              accept;
	logic              mark_rd;
	logic [PAGE_W-1:0] link_rd;
	logic              mark_we;
	logic              link_we;
	logic [PAGE_W-1:0] waddr;
	logic              mark_wd;
	logic [PAGE_W-1:0] link_wd;
	logic [PAGE_W-1:0] head_d;
	logic [CNT_W-1:0]  count_d;
	pfla_rsp_t         rsp_d;
	logic              head_ok;
	logic              page_ok;
	logic [CNT_W-1:0]  cfg_count;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;

	// Free marks: cleared by the sweep after reset
	pfla_ram #(
		.WIDTH (1),
		.DEPTH (MAX_PAGES)
	) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (waddr),
		.wdata (mark_wd),
		.re    (accept),
		.raddr (head_q),
		.rdata (mark_rd)
	);

	// Next links: no reset contents
	pfla_ram #(
		.WIDTH (PAGE_W),
		.DEPTH (MAX_PAGES)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (waddr),
		.wdata (link_wd),
		.re    (accept),
		.raddr (head_q),
		.rdata (link_rd)
	);

	// Page checks against the current count
	assign head_ok = (head_q != '0) && ({1'b0, head_q} < count_q) && mark_rd;
	assign page_ok = (req_q.page_id != '0) && ({1'b0, req_q.page_id} < count_q);

	// Clamp of the written page count
	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_count = CNT_W'(1);
		end else if (cfg_wdata > MAX_COUNT) begin
			cfg_count = MAX_COUNT;
		end else begin
			cfg_count = cfg_wdata;
		end
	end

	// Clearing pass mark writes, and execute: update head, count and memories from the read data
	always_comb begin
		mark_we = 1'b0;
		link_we = 1'b0;
		waddr   = count_q[PAGE_W-1:0];
		mark_wd = 1'b0;
		link_wd = '0;
		head_d  = head_q;
		count_d = count_q;
		rsp_d   = '0;
		if (state_q == S_CLEAR) begin
			mark_we = 1'b1;
			waddr   = clr_addr_q;
		end else if (state_q == S_EXEC) begin
			case (req_q.mode)
				MODE_ALLOC: begin
					if (head_ok) begin
						rsp_d.result_page = head_q;
						rsp_d.from_list   = 1'b1;
						head_d            = link_rd;
					end else begin
						rsp_d.list_dropped = (head_q != '0);
						head_d             = '0;
						if (count_q == MAX_COUNT) begin
							rsp_d.status = ST_FULL;
						end else begin
							// append: fresh page gets mark and link cleared
							mark_we           = 1'b1;
							link_we           = 1'b1;
							count_d           = count_q + 1'b1;
							rsp_d.result_page = count_q[PAGE_W-1:0];
						end
					end
				end
				MODE_FREE: begin
					if (!page_ok) begin
						rsp_d.status = ST_BAD_PAGE;
					end else begin
						mark_we = 1'b1;
						link_we = 1'b1;
						waddr   = req_q.page_id;
						mark_wd = 1'b1;
						link_wd = head_q;
						head_d  = req_q.page_id;
					end
				end
				MODE_SET: begin
					if (!page_ok) begin
						rsp_d.status = ST_BAD_PAGE;
					end else begin
						mark_we = 1'b1;
						link_we = 1'b1;
						waddr   = req_q.page_id;
						mark_wd = req_q.mark_free;
						link_wd = req_q.link_value;
					end
				end
				default: begin
					rsp_d = '0;
				end
			endcase
		end
	end

	// State, list registers and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_addr_q <= '0;
			req_q      <= '0;
			head_q     <= '0;
			count_q    <= CNT_W'(1);
			done_q     <= 1'b0;
			rsp_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == PAGE_W'(MAX_PAGES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						req_q   <= req;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					head_q  <= head_d;
					rsp_q   <= rsp_d;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_we) begin
				count_q <= cfg_count;
			end else if (state_q == S_EXEC) begin
				count_q <= count_d;
			end
		end
	end

`ifndef ASSERT_OFF
	// A result only follows an execute cycle
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_EXEC))
		else $error("result without execute cycle");

	// Page count stays within 1..MAX_PAGES
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= MAX_COUNT))
		else $error("page count out of range");

	// A page popped from the list is never page 0 and always succeeds
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.from_list) |->
			(rsp.status == ST_OK) && (rsp.result_page != '0) && !rsp.list_dropped)
		else $error("bad pop result");

	// An append grows the page count by one
	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.from_list && (rsp.result_page != '0) && !$past(cfg_we))
			|-> (count_q == $past(count_q) + 1'b1))
		else $error("append did not advance page count");
`endif

endmodule

FILE: tb/tb.sv
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pfla_pkg::*;

	// Mode 3 has no meaning to the block; it must answer with an all-zero result
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int NUM_PHASES = 12;
	localparam int PHASE_ITEMS = 140;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	pfla_req_t        req = '0;
	logic             cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic             done;
	pfla_rsp_t        rsp;

	page_free_list_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.rsp       (rsp)
	);

	// Items waiting to be driven, and outcomes waiting on the result port
	pfla_req_t op_q[$];
	pfla_rsp_t outcome_q[$];

	// Shadow of the allocator state
	bit [PAGE_W-1:0] shadow_head = '0;
	int unsigned     shadow_count = 1;
	bit [PAGE_W-1:0] shadow_link [MAX_PAGES];
	bit              shadow_mark [MAX_PAGES];

	// Run bookkeeping
	bit          idle_en = 1'b1;
	int unsigned gap_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned items_taken = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned cfg_writes = 0;
	int unsigned n_pops = 0;
	int unsigned n_appends = 0;
	int unsigned n_full = 0;
	int unsigned n_bad = 0;
	int unsigned n_drops = 0;
	pfla_rsp_t   want;

	initial begin
		forever #5 clk = ~clk;
	end

	// Work out the result of one item and advance the shadow state
	function automatic pfla_rsp_t apply_page_op(input pfla_req_t it);
		pfla_rsp_t r;
		bit        popped;
		bit        pid_ok;
		r = '0;
		popped = 1'b0;
		pid_ok = (it.page_id != 0) && (it.page_id < shadow_count);
		case (it.mode)
			MODE_ALLOC: begin
				if (shadow_head != 0) begin
					if (shadow_head < shadow_count && shadow_mark[shadow_head]) begin
						r.result_page = shadow_head;
						r.from_list = 1'b1;
						shadow_head = shadow_link[shadow_head];
						popped = 1'b1;
						n_pops++;
					end else begin
						// head not free or past the count: list is dropped
						shadow_head = '0;
						r.list_dropped = 1'b1;
						n_drops++;
					end
				end
				if (!popped) begin
					if (shadow_count >= MAX_PAGES) begin
						r.status = ST_FULL;
						n_full++;
					end else begin
						shadow_mark[shadow_count] = 1'b0;
						shadow_link[shadow_count] = '0;
						r.result_page = PAGE_W'(shadow_count);
						shadow_count++;
						n_appends++;
					end
				end
			end
			MODE_FREE: begin
				if (!pid_ok) begin
					r.status = ST_BAD_PAGE;
					n_bad++;
				end else begin
					shadow_mark[it.page_id] = 1'b1;
					shadow_link[it.page_id] = shadow_head;
					shadow_head = it.page_id;
				end
			end
			MODE_SET: begin
				if (!pid_ok) begin
					r.status = ST_BAD_PAGE;
					n_bad++;
				end else begin
					shadow_mark[it.page_id] = it.mark_free;
					shadow_link[it.page_id] = it.link_value;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Random item, biased toward pages that exist at the current count
	function automatic pfla_req_t random_op();
		pfla_req_t   it;
		int unsigned pick;
		int unsigned top;
		top = shadow_count;
		it.mode = MODE_ALLOC;
		it.page_id = PAGE_W'($urandom);
		it.mark_free = 1'($urandom);
		it.link_value = PAGE_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			it.mode = MODE_ALLOC;
		end else if (pick < 85) begin
			it.mode = (pick < 60) ? MODE_FREE : MODE_SET;
			if (top > 1 && $urandom_range(0, 9) != 0)
				it.page_id = PAGE_W'($urandom_range(1, top - 1));
			if (it.mode == MODE_SET && $urandom_range(0, 3) != 0)
				it.link_value = PAGE_W'($urandom_range(0, top - 1));
		end else if (pick < 96) begin
			// page that is out of bounds, or a random one
			it.mode = ($urandom_range(0, 1) != 0) ? MODE_FREE : MODE_SET;
			case ($urandom_range(0, 2))
				0: it.page_id = '0;
				1: if (top < MAX_PAGES) it.page_id = PAGE_W'(top);
				default: ;
			endcase
		end else begin
			it.mode = MODE_UNUSED;
		end
		return it;
	endfunction

	task automatic push_op(input logic [1:0] m, input int unsigned pid, input bit mk,
			input int unsigned lnk);
		pfla_req_t it;
		it.mode = m;
		it.page_id = PAGE_W'(pid);
		it.mark_free = mk;
		it.link_value = PAGE_W'(lnk);
		op_q.push_back(it);
	endtask

	// Block until nothing is queued, presented or outstanding
	task automatic wait_drained();
		do @(posedge clk);
		while (op_q.size() != 0 || start || outcome_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Page count write; only called with the block idle
	task automatic load_page_count(input logic [CNT_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (v < 1)
			shadow_count = 1;
		else if (v > MAX_PAGES)
			shadow_count = MAX_PAGES;
		else
			shadow_count = v;
		cfg_writes++;
	endtask

	task automatic cmp_field(input string fname, input logic [PAGE_W-1:0] exp_v,
			input logic [PAGE_W-1:0] act_v);
		if (act_v !== exp_v) begin
			if (mismatches < 10)
				$display("mismatch on result %0d, %s: expected %0d, got %0d",
					results_seen, fname, exp_v, act_v);
			mismatches++;
		end
	endtask

	// Sender: one item at a time from op_q, with random idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				outcome_q.push_back(apply_page_op(req));
				items_taken++;
			end
			if (start && busy) begin
				// hold the item until it is taken
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (op_q.size() != 0) begin
				if (idle_en && $urandom_range(0, 7) == 0) begin
					gap_left <= $urandom_range(0, 13);
					start <= 1'b0;
				end else begin
					req <= op_q.pop_front();
					start <= 1'b1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				if (mismatches < 10)
					$display("result %0d arrived with no item outstanding: page %0d status %0d",
						results_seen, rsp.result_page, rsp.status);
				mismatches++;
			end else begin
				want = outcome_q.pop_front();
				cmp_field("result_page", want.result_page, rsp.result_page);
				cmp_field("from_list", PAGE_W'(want.from_list), PAGE_W'(rsp.from_list));
				cmp_field("list_dropped", PAGE_W'(want.list_dropped), PAGE_W'(rsp.list_dropped));
				cmp_field("status", PAGE_W'(want.status), PAGE_W'(rsp.status));
			end
			results_seen++;
		end
	end

	// Watchdog on cycles with no item taken and no result
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("timeout after %0d cycles with no progress", WATCHDOG_LIMIT);
				$display("tb: errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Stimulus sequence
	initial begin
		logic [CNT_W-1:0] cnt_val;
		int unsigned      sel;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// let the mark clearing pass finish
		@(posedge clk);
		while (busy) @(posedge clk);

		// Directed part at the reset page count of 1
		push_op(MODE_ALLOC, 0, 0, 0);          // append 1
		push_op(MODE_ALLOC, 0, 0, 0);          // append 2
		push_op(MODE_ALLOC, 0, 0, 0);          // append 3
		push_op(MODE_FREE, 2, 0, 0);
		push_op(MODE_FREE, 3, 0, 0);
		push_op(MODE_ALLOC, 0, 0, 0);          // pop 3
		push_op(MODE_FREE, 3, 0, 0);
		push_op(MODE_FREE, 3, 0, 0);           // double free, page links to itself
		push_op(MODE_ALLOC, 0, 0, 0);          // pop 3, head stays 3
		push_op(MODE_SET, 3, 0, 0);            // unmark the head
		push_op(MODE_ALLOC, 0, 0, 0);          // head not free: drop and append 4
		push_op(MODE_FREE, 1, 0, 0);
		push_op(MODE_SET, 1, 1, MAX_PAGES - 1);
		push_op(MODE_ALLOC, 0, 0, 0);          // pop 1, head past the count
		push_op(MODE_ALLOC, 0, 0, 0);          // drop and append 5
		push_op(MODE_FREE, 0, 1, MAX_PAGES - 1);
		push_op(MODE_FREE, 6, 0, 0);           // page equal to the count
		push_op(MODE_SET, 0, 1, MAX_PAGES - 1);
		push_op(MODE_SET, MAX_PAGES - 1, 1, 0);
		push_op(MODE_UNUSED, MAX_PAGES - 1, 1, MAX_PAGES - 1);
		push_op(MODE_ALLOC, MAX_PAGES - 1, 1, MAX_PAGES - 1);
		push_op(MODE_SET, 2, 1, 0);
		push_op(MODE_FREE, 5, 0, 0);
		push_op(MODE_ALLOC, 0, 0, 0);          // pop 5
		wait_drained();

		// Random phases, each at its own page count
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: cnt_val = '0;
				1: cnt_val = '1;
				2: cnt_val = CNT_W'(MAX_PAGES - 1);
				3: cnt_val = MAX_COUNT;
				4: cnt_val = CNT_W'(1);
				default: begin
					sel = $urandom_range(0, 9);
					if (sel < 7)
						cnt_val = CNT_W'($urandom_range(2, 64));
					else if (sel < 9)
						cnt_val = CNT_W'($urandom_range(65, MAX_PAGES));
					else
						cnt_val = CNT_W'($urandom);
				end
			endcase
			load_page_count(cnt_val);
			if (ph == NUM_PHASES - 1)
				idle_en = 1'b0;
			// one below capacity: append the last page, then hit full
			if (ph == 2) begin
				push_op(MODE_ALLOC, 0, 0, 0);
				push_op(MODE_ALLOC, 0, 0, 0);
				push_op(MODE_ALLOC, 0, 0, 0);
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				while (op_q.size() >= 2) @(posedge clk);
				op_q.push_back(random_op());
			end
			wait_drained();
		end

		$display("covered %0d items over %0d count writes: %0d pops, %0d appends, %0d full",
			items_taken, cfg_writes, n_pops, n_appends, n_full);
		$display("%0d bad page, %0d list drops, %0d results checked, %0d mismatches",
			n_bad, n_drops, results_seen, mismatches);
		if (mismatches == 0 && outcome_q.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

`default_nettype wire
